@@ rtl/button_edge_event_tracker_core_defines.svh @@
// Assertion macros for the button edge event tracker.
// Included by the top level; depends on nothing else.
`ifndef BUTTON_EDGE_EVENT_TRACKER_CORE_DEFINES_SVH
`define BUTTON_EDGE_EVENT_TRACKER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BETT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BETT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bett_pkg.sv @@
// Shared types, codes and a helper function for the button edge event tracker.
// No dependencies.
package bett_pkg;

    localparam int APB_AW = 3;
    localparam logic [31:0] STALE_LIMIT_RESET = 32'd100000;

    typedef enum logic [0:0] {
        REG_STALE_LIMIT = 1'b0
    } t_reg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [0:0] {
        KIND_DOWN = 1'b0,
        KIND_UP   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [31:0] press;
        logic [31:0] rel;
        logic [31:0] levels;
        logic [63:0] stamp;
    } t_rec;

    typedef struct packed {
        logic       flag;
        logic [4:0] button_index;
        logic       event_kind;
    } t_result;

    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/bett_if.sv @@
// Valid/ready channel interfaces for the button edge event tracker.
// Depends on nothing.
interface bett_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  task_req;
    logic [31:0] button_levels;
    logic [63:0] now_us;

    modport source (output valid, output func, output task_req, output button_levels,
                    output now_us, input ready);
    modport sink (input valid, input func, input task_req, input button_levels,
                  input now_us, output ready);
endinterface

interface bett_out_if;
    logic       valid;
    logic       ready;
    logic       flag;
    logic [4:0] button_index;
    logic       event_kind;

    modport source (output valid, output flag, output button_index, output event_kind,
                    input ready);
    modport sink (input valid, input flag, input button_index, input event_kind,
                  output ready);
endinterface

@@ rtl/bett_cfg.sv @@
// APB register block holding the stale limit.
// Depends on bett_pkg.
module bett_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bett_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [31:0]                o_stale_limit
);
    import bett_pkg::*;

    logic [31:0] r_stale_limit;
    logic        s_sel_limit;

    assign s_sel_limit = (paddr[2] == REG_STALE_LIMIT);
    assign pready = 1'b1;
    assign prdata = s_sel_limit ? r_stale_limit : 32'd0;
    assign o_stale_limit = r_stale_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= STALE_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && s_sel_limit) begin
            r_stale_limit <= pwdata;
        end
    end

endmodule

@@ rtl/bett_engine.sv @@
// Record update and event selection for one item against one task record.
// Depends on bett_pkg.
module bett_engine #(
    parameter int BUTTON_COUNT = 32
) (
    input  logic [1:0]       i_func,
    input  logic [31:0]      i_levels,
    input  logic [63:0]      i_now,
    input  logic [31:0]      i_stale_limit,
    input  bett_pkg::t_rec   i_rec,
    output bett_pkg::t_rec   o_rec,
    output logic             o_wr,
    output bett_pkg::t_result o_res
);
    import bett_pkg::*;

    localparam logic [31:0] BTN_MASK = 32'hFFFF_FFFF >> (32 - BUTTON_COUNT);

    logic [31:0] s_lv;
    logic [31:0] s_st;
    logic [63:0] s_age;
    logic        s_stale;
    logic [31:0] s_pp0, s_pr0, s_pp1, s_pr1, s_pp2, s_pr2;
    logic [31:0] s_ev, s_m;
    logic [4:0]  s_idx;
    logic        s_down;

    assign s_lv    = i_levels & BTN_MASK;
    assign s_st    = i_rec.levels;
    assign s_age   = i_now - i_rec.stamp;
    assign s_stale = s_age > {32'd0, i_stale_limit};

    assign s_pp0 = (i_func == FUNC_GET && s_stale) ? 32'd0 : i_rec.press;
    assign s_pr0 = (i_func == FUNC_GET && s_stale) ? 32'd0 : i_rec.rel;
    assign s_pp1 = (s_pp0 | (s_lv & ~s_st)) & BTN_MASK;
    assign s_pr1 = (s_pr0 | (~s_lv & s_st)) & BTN_MASK;

    // repair combinations that cannot be reported
    assign s_pr2 = s_pr1 & (s_pp1 | s_st);
    assign s_pp2 = s_pp1 & (s_pr2 | ~s_st);
    assign s_ev  = (s_pp2 & ~s_st) | (s_pr2 & s_st);
    assign s_idx = lowest_set(s_ev);
    assign s_m   = (s_ev != 32'd0) ? (32'd1 << s_idx) : 32'd0;
    assign s_down = ((s_pp2 & s_m) != 32'd0) && ((s_st & s_m) == 32'd0);

    always_comb begin
        o_rec = i_rec;
        o_wr  = 1'b0;
        o_res = '0;
        unique case (i_func)
            FUNC_SAMPLE: begin
                o_wr        = 1'b1;
                o_rec.press = s_pp1;
                o_rec.rel   = s_pr1;
                o_rec.stamp = i_now;
                o_res.flag  = (s_pp1 | s_pr1) != 32'd0;
            end
            FUNC_GET: begin
                o_wr        = 1'b1;
                o_rec.press = s_pp2;
                o_rec.rel   = s_pr2;
                if (s_ev != 32'd0) begin
                    o_res.flag         = 1'b1;
                    o_res.button_index = s_idx;
                    if (s_down) begin
                        o_rec.press      = s_pp2 & ~s_m;
                        o_rec.levels     = s_st | s_m;
                        o_res.event_kind = KIND_DOWN;
                    end else begin
                        o_rec.rel        = s_pr2 & ~s_m;
                        o_rec.levels     = s_st & ~s_m;
                        o_res.event_kind = KIND_UP;
                    end
                end
            end
            FUNC_CLEAR: begin
                o_wr  = 1'b1;
                o_rec = '0;
            end
            default: begin
                o_wr = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/button_edge_event_tracker_core.sv @@
// Button edge event tracker: one press/release record per task.
// Items enter on i_in (valid/ready); one result per item leaves on o_out.
// Func sample latches edges and stamps the time; get drops stale edges,
// latches, repairs and reports the lowest pending change; clear zeroes.
// The stale limit sits in an APB register at address 0 (reset 100000).
// An item enters the input register at its transfer edge; its result is
// loaded into the result register, raising o_out.valid, when the input
// register advances, which waits while a held result is not taken.
// Throughput is one item per cycle while results are taken; each record
// write is seen by the next item, so back-to-back items to one task chain.
// Reset clears all task records and both pipeline stages and restores the
// stale limit to 100000.
// When the receiver stalls, the result register holds and the input
// register fills; i_in.ready drops once both are occupied.
// Depends on bett_pkg, bett_if, bett_cfg, bett_engine and the defines header.
`include "button_edge_event_tracker_core_defines.svh"
module button_edge_event_tracker_core #(
    parameter int TASK_COUNT   = 8,
    parameter int BUTTON_COUNT = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bett_in_if.sink                     i_in,
    bett_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bett_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bett_pkg::*;

    localparam int TIDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    t_rec        r_rec [TASK_COUNT];
    logic        r_s1_valid;
    logic [1:0]  r_s1_func;
    logic [2:0]  r_s1_task;
    logic [31:0] r_s1_lv;
    logic [63:0] r_s1_now;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic [31:0]       s_stale_limit;
    logic              s_adv;
    logic              s_task_ok;
    logic [TIDX_W-1:0] s_idx;
    t_rec              s_rec;
    t_rec              s_rec_next;
    logic              s_wr;
    t_result           s_res;

    bett_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_stale_limit (s_stale_limit)
    );

    assign s_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s_adv;
    assign s_task_ok  = {29'd0, r_s1_task} < 32'(TASK_COUNT);
    assign s_idx      = TIDX_W'(r_s1_task);
    assign s_rec      = s_task_ok ? r_rec[s_idx] : '0;

    bett_engine #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_engine (
        .i_func        (r_s1_func),
        .i_levels      (r_s1_lv),
        .i_now         (r_s1_now),
        .i_stale_limit (s_stale_limit),
        .i_rec         (s_rec),
        .o_rec         (s_rec_next),
        .o_wr          (s_wr),
        .o_res         (s_res)
    );

    assign n_out = s_task_ok ? s_res : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_func <= i_in.func;
            r_s1_task <= i_in.task_req;
            r_s1_lv   <= i_in.button_levels;
            r_s1_now  <= i_in.now_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TASK_COUNT; t++) begin
                r_rec[t] <= '0;
            end
        end else if (s_adv && s_task_ok && s_wr) begin
            r_rec[s_idx] <= s_rec_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.flag         = r_out.flag;
    assign o_out.button_index = r_out.button_index;
    assign o_out.event_kind   = r_out.event_kind;

    `BETT_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, r_s1_valid && r_out_valid && !o_out.ready, !i_in.ready, "input taken while both stages are stalled")
    `BETT_ASSERT_NOW(a_kind_flag, i_clk, i_rst_n, o_out.valid && o_out.event_kind, o_out.flag, "up event without flag")
    `BETT_ASSERT_NEXT(a_adv_valid, i_clk, i_rst_n, s_adv, o_out.valid, "advanced item missing at output")

endmodule

@@ tb/sv/button_edge_event_tracker_core_tb.sv @@
// Self-checking testbench for button_edge_event_tracker_core: directed cases, random
// per-task press/release sessions under several stale limits, and a long output stall.
// Depends on bett_pkg, bett_if and the RTL of the tracker.
module button_edge_event_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bett_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] STALE_ADDR = APB_AW'(4 * REG_STALE_LIMIT);

    typedef struct {
        logic [1:0]  func;
        logic [2:0]  task_id;
        logic [31:0] levels;
        logic [63:0] now;
    } t_btn_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bett_in_if in_if();
    bett_out_if out_if();

    button_edge_event_tracker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Tracker model state
    logic [31:0] stale_limit;
    logic [31:0] rec_press [8];
    logic [31:0] rec_release [8];
    logic [31:0] rec_levels [8];
    logic [63:0] rec_stamp [8];

    t_result expected_events [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int rx_stall = 0;
    int hold_req_cnt = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Stimulus-side view of each task's buttons and clock
    logic [31:0] cur_levels [8];
    logic [63:0] cur_now [8];

    always #2 i_clk = ~i_clk;

    initial begin
        in_if.valid = 1'b0;
        in_if.func = '0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void capture_edges(input int t, input logic [31:0] lv);
        rec_press[t] = rec_press[t] | (lv & ~rec_levels[t]);
        rec_release[t] = rec_release[t] | (~lv & rec_levels[t]);
    endfunction

    function automatic t_result track_button_event(input t_btn_item it);
        t_result r;
        logic [31:0] st;
        logic [31:0] ev;
        logic [31:0] m;
        int t;
        int idx;
        r = '0;
        t = it.task_id;
        idx = 0;
        case (it.func)
            FUNC_SAMPLE: begin
                capture_edges(t, it.levels);
                rec_stamp[t] = it.now;
                r.flag = (rec_press[t] | rec_release[t]) != '0;
            end
            FUNC_GET: begin
                if (it.now - rec_stamp[t] > {32'd0, stale_limit}) begin
                    rec_press[t] = '0;
                    rec_release[t] = '0;
                end
                capture_edges(t, it.levels);
                st = rec_levels[t];
                rec_release[t] = rec_release[t] & (rec_press[t] | st);
                rec_press[t] = rec_press[t] & (rec_release[t] | ~st);
                ev = (rec_press[t] & ~st) | (rec_release[t] & st);
                if (ev != '0) begin
                    for (int i = 31; i >= 0; i--) begin
                        if (ev[i]) begin
                            idx = i;
                        end
                    end
                    m = 32'd1 << idx;
                    if (rec_press[t][idx] && !st[idx]) begin
                        rec_press[t] = rec_press[t] & ~m;
                        rec_levels[t] = rec_levels[t] | m;
                        r.event_kind = KIND_DOWN;
                    end else begin
                        rec_release[t] = rec_release[t] & ~m;
                        rec_levels[t] = rec_levels[t] & ~m;
                        r.event_kind = KIND_UP;
                    end
                    r.flag = 1'b1;
                    r.button_index = 5'(idx);
                end
            end
            FUNC_CLEAR: begin
                rec_press[t] = '0;
                rec_release[t] = '0;
                rec_levels[t] = '0;
                rec_stamp[t] = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(99);
        if (!enabled || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    function automatic t_btn_item button_item(input logic [1:0] f, input logic [2:0] t,
                                              input logic [31:0] lv, input logic [63:0] now);
        t_btn_item it;
        it.func = f;
        it.task_id = t;
        it.levels = lv;
        it.now = now;
        return it;
    endfunction

    // Predict each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            expected_events.push_back(track_button_event(button_item(in_if.func,
                in_if.task_req, in_if.button_levels, in_if.now_us)));
        end
    end

    // Check each output transfer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_events.pop_front();
                if (out_if.flag !== want.flag) begin
                    report_mismatch("flag", out_if.flag, want.flag);
                end
                if (out_if.button_index !== want.button_index) begin
                    report_mismatch("button_index", out_if.button_index, want.button_index);
                end
                if (out_if.event_kind !== want.event_kind) begin
                    report_mismatch("event_kind", out_if.event_kind, want.event_kind);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
        end else if (rx_idle_en && $urandom_range(99) < 25) begin
            rx_stall = pick_gap(1'b1);
        end
        out_if.ready <= (rx_stall == 0) && (hold_left == 0);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(input t_btn_item it);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.func <= it.func;
        in_if.task_req <= it.task_id;
        in_if.button_levels <= it.levels;
        in_if.now_us <= it.now;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [31:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= STALE_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            report_mismatch("stale limit readback", prdata, want);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_stale_limit(input logic [31:0] value);
        wait_drain();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= STALE_ADDR;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        stale_limit = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apb_read_check(value);
    endtask

    task automatic test_reset_values();
        stale_limit = STALE_LIMIT_RESET;
        for (int t = 0; t < 8; t++) begin
            rec_press[t] = '0;
            rec_release[t] = '0;
            rec_levels[t] = '0;
            rec_stamp[t] = '0;
            cur_levels[t] = '0;
            cur_now[t] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(STALE_LIMIT_RESET);
    endtask

    task automatic test_directed_cases();
        t_btn_item items [$];
        items.push_back(button_item(FUNC_SAMPLE, 3'd0, 32'hFFFF_FFFF, 64'd10));
        items.push_back(button_item(FUNC_GET, 3'd0, 32'hFFFF_FFFF, 64'd20));
        items.push_back(button_item(FUNC_GET, 3'd0, 32'hFFFF_FFFF, 64'd30));
        items.push_back(button_item(FUNC_SAMPLE, 3'd0, 32'h0000_0000, 64'd40));
        items.push_back(button_item(FUNC_GET, 3'd0, 32'h0000_0000, 64'd50));
        items.push_back(button_item(FUNC_GET, 3'd0, 32'h0000_0000, 64'd60));
        items.push_back(button_item(FUNC_SAMPLE, 3'd7, 32'h8000_0000, '1));
        items.push_back(button_item(FUNC_GET, 3'd7, 32'h8000_0000, '1));
        items.push_back(button_item(FUNC_GET, 3'd7, 32'h0000_0000, 64'd0));
        items.push_back(button_item(FUNC_SAMPLE, 3'd3, 32'h0001_0000, 64'd5000));
        items.push_back(button_item(FUNC_GET, 3'd3, 32'h0001_0000, 64'd4000));
        items.push_back(button_item(FUNC_SAMPLE, 3'd2, 32'h0000_0005, 64'd1000));
        items.push_back(button_item(FUNC_GET, 3'd2, 32'h0000_0005, 64'd101000));
        items.push_back(button_item(FUNC_GET, 3'd2, 32'h0000_0005, 64'd101001));
        items.push_back(button_item(FUNC_CLEAR, 3'd0, 32'hFFFF_FFFF, '1));
        items.push_back(button_item(FUNC_GET, 3'd0, 32'hFFFF_FFFF, 64'd70));
        items.push_back(button_item(FUNC_UNUSED, 3'd1, 32'hFFFF_FFFF, '1));
        items.push_back(button_item(FUNC_GET, 3'd5, 32'h0000_0000, 64'd0));
        items.push_back(button_item(FUNC_SAMPLE, 3'd4, 32'hAAAA_AAAA, 64'd123));
        items.push_back(button_item(FUNC_SAMPLE, 3'd4, 32'h5555_5555, 64'd124));
        items.push_back(button_item(FUNC_GET, 3'd4, 32'h5555_5555, 64'd125));
        items.push_back(button_item(FUNC_GET, 3'd4, 32'h0000_0000, 64'd126));
        foreach (items[i]) begin
            send_item(items[i]);
        end
        release_input();
    endtask

    task automatic run_sessions(input int count);
        t_btn_item it;
        int t;
        int focus;
        int roll;
        focus = $urandom_range(7);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(15) == 0) begin
                focus = $urandom_range(7);
            end
            t = ($urandom_range(3) == 0) ? $urandom_range(7) : focus;
            roll = $urandom_range(99);
            if (roll < 3) begin
                cur_now[t] = cur_now[t] - $urandom_range(5000, 1);
            end else if (roll < 8) begin
                cur_now[t] = cur_now[t] + {32'd0, stale_limit} + $urandom_range(1000, 1);
            end else begin
                cur_now[t] = cur_now[t] + $urandom_range(2000);
            end
            roll = $urandom_range(99);
            if (roll < 5) begin
                cur_levels[t] = $urandom();
            end else if (roll < 70) begin
                cur_levels[t] = cur_levels[t] ^ (32'd1 << $urandom_range(31));
                if (roll < 25) begin
                    cur_levels[t] = cur_levels[t] ^ (32'd1 << $urandom_range(31));
                end
            end
            roll = $urandom_range(99);
            if (roll < 45) begin
                it = button_item(FUNC_SAMPLE, 3'(t), cur_levels[t], cur_now[t]);
            end else if (roll < 85) begin
                it = button_item(FUNC_GET, 3'(t), cur_levels[t], cur_now[t]);
            end else if (roll < 90) begin
                it = button_item(FUNC_CLEAR, 3'(t), $urandom(), {$urandom(), $urandom()});
            end else if (roll < 94) begin
                it = button_item(FUNC_UNUSED, 3'(t), $urandom(), {$urandom(), $urandom()});
            end else begin
                it = button_item(($urandom_range(1) == 0) ? FUNC_SAMPLE : FUNC_GET, 3'(t),
                                 $urandom(), {$urandom(), $urandom()});
            end
            send_item(it);
        end
        release_input();
    endtask

    task automatic test_long_stale_limit();
        set_stale_limit(32'hFFFF_FFFF);
        for (int t = 0; t < 8; t++) begin
            cur_now[t] = {$urandom(), $urandom()};
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_sessions(90);
    endtask

    task automatic test_zero_stale_limit();
        set_stale_limit(32'd0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b0;
        run_sessions(90);
    endtask

    task automatic test_short_stale_limit();
        set_stale_limit($urandom_range(5000, 500));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        run_sessions(90);
    endtask

    task automatic test_default_stale_limit();
        set_stale_limit(STALE_LIMIT_RESET);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_sessions(60);
    endtask

    task automatic test_output_stall();
        wait_drain();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        @(negedge i_clk);
        hold_req_cnt++;
        run_sessions(50);
    endtask

    initial begin
        out_if.ready = 1'b0;
        test_reset_values();
        test_directed_cases();
        test_long_stale_limit();
        test_zero_stale_limit();
        test_short_stale_limit();
        test_default_stale_limit();
        test_output_stall();
        wait_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bett_pkg.sv
rtl/bett_if.sv
rtl/bett_cfg.sv
rtl/bett_engine.sv
rtl/button_edge_event_tracker_core.sv
tb/sv/button_edge_event_tracker_core_tb.sv
